// File: hdl/bqc_pkg.sv
package bqc_pkg;

  localparam int MAX_SECTIONS_DEF = 4;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int DATA_W   = 24;
  localparam int PROD_W   = COEF_W + DATA_W;
  localparam int FRAC_SH  = 14;
  localparam int SUM_W    = DATA_W + 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CNT_REG_W  = 3;
  localparam int COEF_REGS  = 4;

  localparam logic [COEF_W-1:0]    GAIN_RESET = 16'sd16384;
  localparam logic [CNT_REG_W-1:0] COUNT_RESET = 3'd1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEC0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEC3  = 3'd5;

  // kinds of product on the shared multiplier
  localparam logic [2:0] K_GAIN = 3'd0;
  localparam logic [2:0] K_A1   = 3'd1;
  localparam logic [2:0] K_A2   = 3'd2;
  localparam logic [2:0] K_B1   = 3'd3;
  localparam logic [2:0] K_B2   = 3'd4;

  typedef logic signed [DATA_W-1:0] data_t;

  function automatic data_t sat24(input logic signed [SUM_W-1:0] v);
    data_t r;
    if (v > SUM_W'(signed'(24'sh7fffff))) begin
      r = 24'sh7fffff;
    end else if (v < SUM_W'(signed'(24'sh800000))) begin
      r = 24'sh800000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic clip24(input logic signed [SUM_W-1:0] v);
    return (v > SUM_W'(signed'(24'sh7fffff))) || (v < SUM_W'(signed'(24'sh800000)));
  endfunction

endpackage

// File: hdl/biquad_cascade_iir_filter_unit.sv
// Cascaded biquad IIR filter, direct form II, fixed point.
// Input: in_tvalid/in_tready/in_tdata carry one Q1.15 sample per request.
// Output: out_tvalid/out_tready/out_tdata carry the filtered sample, with
// out_tuser high when any saturation occurred on the way.
// Config: cfg_valid/cfg_ready/cfg_index/cfg_data write gain (0), section
// count (1) and the packed coefficients of sections 0..3 (2..5); cfg_ready
// is always high. Write only while the filter is idle.
// Timing: one 16x24 multiplier is shared by the gain product and the four
// products of each section, one product a cycle, with the add/saturate in the
// cycle after. After the last product the sequencer passes the drain and
// output steps, and out_tvalid rises from the output register. in_tready is
// high only while idle, so no new sample is taken until the sequencer is idle.
// A result that the receiver stalls is held in the output register, and the
// next sample is accepted meanwhile; its own result waits for the register.
// Reset (rst_n low, synchronous) clears the delay words, the coefficients,
// sets gain to 1.0 and the section count to one.
module biquad_cascade_iir_filter_unit
  import bqc_pkg::*;
#(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,   // [15:0] sample_in
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [SAMPLE_W-1:0]   out_tdata,  // [15:0] sample_out
  output logic                  out_tuser,  // [0] clipped
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W    = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int SEC_W    = $clog2(MAX_SECTIONS + 1);
  localparam int NUM_COEF = (MAX_SECTIONS < COEF_REGS) ? MAX_SECTIONS : COEF_REGS;
  localparam int CIDX_W   = (NUM_COEF > 1) ? $clog2(NUM_COEF) : 1;
  localparam logic [SEC_W-1:0] MAX_CNT = SEC_W'(MAX_SECTIONS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ISSUE  = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_OUTPUT = 2'd3;

  logic [1:0]                state_r;
  logic signed [COEF_W-1:0]  gain_r;
  logic [CNT_REG_W-1:0]      count_cfg_r;
  logic [CFG_DATA_W-1:0]     coef_r [NUM_COEF];
  data_t                     dly1_r [MAX_SECTIONS];
  data_t                     dly2_r [MAX_SECTIONS];

  logic signed [SAMPLE_W-1:0] x_r;
  logic [SEC_W-1:0]          cnt_r;
  logic [2:0]                iss_kind_r;
  logic [IDX_W-1:0]          iss_sec_r;
  logic                      iss_last;

  logic signed [PROD_W-1:0]  prod_r;
  logic                      p_valid_r;
  logic [2:0]                p_kind_r;
  logic [IDX_W-1:0]          p_sec_r;

  data_t                     acc_r;
  data_t                     w_r;
  logic                      clip_r;

  logic                      out_tvalid_r;
  logic [SAMPLE_W-1:0]       out_tdata_r;
  logic                      out_tuser_r;

  logic [SEC_W-1:0]          cnt_nxt;
  logic [CFG_DATA_W-1:0]     cw;
  logic signed [COEF_W-1:0]  mul_coef;
  data_t                     mul_data;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [SUM_W-1:0]   prod_sh;
  logic signed [SUM_W-1:0]   acc_ext;
  logic signed [SUM_W-1:0]   sum;
  data_t                     acc_nxt;
  logic                      sat_hit;
  logic [SAMPLE_W-1:0]       final_val;
  logic                      final_clip;
  logic [CFG_IDX_W-1:0]      cfg_sec;
  logic                      out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_free   = !out_tvalid_r || out_tready;

  // clamp the section count at the number of sections built
  assign cnt_nxt = (32'(count_cfg_r) > 32'(MAX_SECTIONS)) ? MAX_CNT : SEC_W'(count_cfg_r);

  // operand select for the shared multiplier
  always_comb begin
    cw = '0;
    if (32'(iss_sec_r) < NUM_COEF) begin
      cw = coef_r[iss_sec_r[CIDX_W-1:0]];
    end
    case (iss_kind_r)
      K_GAIN: begin
        mul_coef = gain_r;
        mul_data = DATA_W'(x_r);
      end
      K_A1: begin
        mul_coef = cw[15:0];
        mul_data = dly1_r[iss_sec_r];
      end
      K_A2: begin
        mul_coef = cw[31:16];
        mul_data = dly2_r[iss_sec_r];
      end
      K_B1: begin
        mul_coef = cw[47:32];
        mul_data = dly1_r[iss_sec_r];
      end
      K_B2: begin
        mul_coef = cw[63:48];
        mul_data = dly2_r[iss_sec_r];
      end
      default: begin
        mul_coef = '0;
        mul_data = '0;
      end
    endcase
  end

  assign prod_nxt = mul_coef * mul_data;
  assign iss_last = (iss_kind_r == K_GAIN && cnt_r == '0) ||
                    (iss_kind_r == K_B2 && (SEC_W'(iss_sec_r) + SEC_W'(1)) == cnt_r);

  // add/subtract stage, in the cycle after the multiplier
  always_comb begin
    logic signed [PROD_W-1:0] shd;
    shd     = prod_r >>> FRAC_SH;
    prod_sh = shd[SUM_W-1:0];
    acc_ext = SUM_W'(acc_r);
    case (p_kind_r)
      K_GAIN:     sum = prod_sh;
      K_A1, K_A2: sum = acc_ext - prod_sh;
      K_B1, K_B2: sum = acc_ext + prod_sh;
      default:    sum = acc_ext;
    endcase
    acc_nxt = sat24(sum);
    sat_hit = clip24(sum);
  end

  always_comb begin
    if (acc_r > DATA_W'(signed'(16'sh7fff))) begin
      final_val  = 16'h7fff;
      final_clip = 1'b1;
    end else if (acc_r < DATA_W'(signed'(16'sh8000))) begin
      final_val  = 16'h8000;
      final_clip = 1'b1;
    end else begin
      final_val  = acc_r[SAMPLE_W-1:0];
      final_clip = 1'b0;
    end
  end

  assign cfg_sec = cfg_index - REG_SEC0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_RESET;
      count_cfg_r <= COUNT_RESET;
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN:  gain_r <= cfg_data[COEF_W-1:0];
        REG_COUNT: count_cfg_r <= cfg_data[CNT_REG_W-1:0];
        default: begin
          if (cfg_index >= REG_SEC0 && cfg_index <= REG_SEC3 && 32'(cfg_sec) < NUM_COEF) begin
            coef_r[cfg_sec[CIDX_W-1:0]] <= cfg_data;
          end
        end
      endcase
    end
  end

  // sequencer and datapath control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      p_valid_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
      iss_kind_r   <= K_GAIN;
      iss_sec_r    <= '0;
      cnt_r        <= '0;
      clip_r       <= 1'b0;
      for (int i = 0; i < MAX_SECTIONS; i++) begin
        dly1_r[i] <= '0;
        dly2_r[i] <= '0;
      end
    end else begin
      if (state_r == ST_OUTPUT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      p_valid_r <= (state_r == ST_ISSUE);
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            x_r        <= in_tdata;
            cnt_r      <= cnt_nxt;
            iss_kind_r <= K_GAIN;
            iss_sec_r  <= '0;
            clip_r     <= 1'b0;
            state_r    <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          prod_r    <= prod_nxt;
          p_kind_r  <= iss_kind_r;
          p_sec_r   <= iss_sec_r;
          if (iss_last) begin
            state_r <= ST_DRAIN;
          end else if (iss_kind_r == K_B2) begin
            iss_kind_r <= K_A1;
            iss_sec_r  <= iss_sec_r + IDX_W'(1);
          end else begin
            iss_kind_r <= iss_kind_r + 3'd1;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_OUTPUT;
        end
        ST_OUTPUT: begin
          if (out_free) begin
            out_tdata_r  <= final_val;
            out_tuser_r  <= clip_r || final_clip;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (p_valid_r) begin
        acc_r  <= acc_nxt;
        clip_r <= clip_r || sat_hit;
        if (p_kind_r == K_A2) begin
          w_r <= acc_nxt;
        end
        // shift the section's delay line once its last product is in
        if (p_kind_r == K_B2) begin
          dly1_r[p_sec_r] <= w_r;
          dly2_r[p_sec_r] <= dly1_r[p_sec_r];
        end
      end
    end
  end

`ifndef SYNTH
  a_pipe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r |-> (state_r == ST_ISSUE || state_r == ST_DRAIN))
    else $error("product stage active outside a sample");

  a_drain_next: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |=> state_r == ST_OUTPUT && !p_valid_r)
    else $error("last product not followed by output");

  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == ST_OUTPUT)
    else $error("result raised outside output step");

  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ISSUE && iss_kind_r != K_GAIN) |-> SEC_W'(iss_sec_r) < cnt_r)
    else $error("section index beyond count in use");

  a_gain_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_tvalid) |=> (state_r == ST_ISSUE && iss_kind_r == K_GAIN))
    else $error("sample does not start with the gain product");
`endif

endmodule
